>>> rtl/ttcc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ttcc_pkg;

  // Cell command codes.
  typedef enum logic [1:0] {
    CMD_DRAW         = 2'd0,
    CMD_CLEAR_CELL   = 2'd1,
    CMD_SCROLL       = 2'd2,
    CMD_CLEAR_SCREEN = 2'd3
  } cmd_code_t;

  // Configuration register indexes.
  localparam logic [1:0] CFG_COLUMNS    = 2'd0;
  localparam logic [1:0] CFG_ROWS       = 2'd1;
  localparam logic [1:0] CFG_CLEAR_CODE = 2'd2;

  // Special characters.
  localparam logic [7:0] CH_ESC_COLOUR = 8'hFE;
  localparam logic [7:0] CH_BACKSPACE  = 8'h08;
  localparam logic [7:0] CH_NEWLINE    = 8'h0A;
  localparam logic [7:0] CH_CURSOR     = 8'h5F;

  // Register reset values.
  localparam logic [7:0] COLUMNS_RESET    = 8'd88;
  localparam logic [6:0] ROWS_RESET       = 7'd30;
  localparam logic [7:0] CLEAR_CODE_RESET = 8'd12;
  localparam logic [7:0] COLOUR_RESET     = 8'd1;

  // One cell command as held in the command buffer.
  typedef struct packed {
    cmd_code_t   command;
    logic [7:0]  glyph;
    logic [6:0]  cell_col;
    logic [5:0]  cell_row;
    logic [23:0] rgb;
  } cell_cmd_t;

  // Palette lookup; indexes without a colour give black.
  function automatic logic [23:0] pal_rgb(input logic [7:0] idx);
    logic [23:0] c;
    unique case (idx)
      8'd1:    c = 24'h989898;
      8'd2:    c = 24'hFFFFFF;
      8'd3:    c = 24'h0080FF;
      8'd4:    c = 24'h008000;
      8'd5:    c = 24'hFF5050;
      default: c = 24'h000000;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

>>> rtl/ttcc_char_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface ttcc_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;

  modport source (output valid, output char_in, input ready);
  modport sink   (input valid, input char_in, output ready);
endinterface

`default_nettype wire

>>> rtl/ttcc_cmd_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface ttcc_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [7:0]  glyph;
  logic [6:0]  cell_col;
  logic [5:0]  cell_row;
  logic [23:0] rgb;
  logic        last;

  modport source (output valid, output command, output glyph, output cell_col,
                  output cell_row, output rgb, output last, input ready);
  modport sink   (input valid, input command, input glyph, input cell_col,
                  input cell_row, input rgb, input last, output ready);
endinterface

`default_nettype wire

>>> rtl/text_terminal_cursor_controller.sv
// Character-cell terminal cursor controller.
// The chr channel takes one character byte per request. The cmd channel
// gives the cell commands that byte causes (two to four), the final one
// marked with last: erase of the underscore cursor, the byte's own work
// (glyph, cell clear, scroll, screen clear) and the cursor redraw.
// The cfg port writes columns, rows and clear_code by index; write it only
// while the block is idle.
// A byte is decoded in its accept cycle into a four-entry command buffer,
// which then drains one command per cycle, while the receiver keeps up,
// into the output register; a byte's first command is thus valid once it
// has passed through the buffer and then the output register. The input
// takes no new byte while the buffer still holds the last byte's commands.
// The next byte is accepted in the cycle the last buffered command moves
// to the output register, so bytes follow with no gap while the receiver
// keeps up. When the receiver stalls, the output register holds and the
// buffer waits.
// Reset (rst, synchronous) restores columns 88, rows 30, clear_code 12,
// the cursor to home, colour index 1 and no pending colour escape, and
// empties the buffer and the output register.
`timescale 1ns / 1ps
`default_nettype none

module text_terminal_cursor_controller #(
  parameter int MAX_COLS = 128,
  parameter int MAX_ROWS = 64
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_wr_en,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_data,
  ttcc_char_if.sink       chr,
  ttcc_cmd_if.source      cmd
);

  localparam int COL_LIM = (MAX_COLS < 128) ? MAX_COLS : 128;
  localparam int ROW_LIM = (MAX_ROWS < 64) ? MAX_ROWS : 64;

  // Configuration and terminal state.
  logic [7:0] columns;
  logic [6:0] rows;
  logic [7:0] clear_code;
  logic [6:0] cursor_col;
  logic [5:0] cursor_row;
  logic [7:0] colour_index;
  logic       colour_pending;

  logic [6:0] cursor_col_next;
  logic [5:0] cursor_row_next;
  logic [7:0] colour_index_next;
  logic       colour_pending_next;

  // Command buffer.
  ttcc_pkg::cell_cmd_t cbuf [4];
  ttcc_pkg::cell_cmd_t cbuf_next [4];
  logic       buf_has;
  logic [1:0] buf_idx;
  logic [1:0] buf_cnt_m1;
  logic [1:0] buf_cnt_m1_next;

  logic out_load;
  logic buf_take;
  logic buf_done;
  logic accept;

  // Output register.
  logic                out_valid;
  ttcc_pkg::cell_cmd_t out_cmd;
  logic                out_last;

  // Effective screen size.
  logic [7:0] eff_cols;
  logic [6:0] eff_rows;

  always_comb begin
    eff_cols = (columns == 8'd0) ? 8'd1 : columns;
    if (eff_cols > 8'(COL_LIM)) begin
      eff_cols = 8'(COL_LIM);
    end
    eff_rows = (rows == 7'd0) ? 7'd1 : rows;
    if (eff_rows > 7'(ROW_LIM)) begin
      eff_rows = 7'(ROW_LIM);
    end
  end

  // Handshake between buffer, output register and input.
  assign out_load  = !out_valid || cmd.ready;
  assign buf_take  = buf_has && out_load;
  assign buf_done  = buf_take && (buf_idx == buf_cnt_m1);
  assign chr.ready = !buf_has || buf_done;
  assign accept    = chr.valid && chr.ready;

  // Decode one byte into its command list and the next state.
  always_comb begin
    ttcc_pkg::cell_cmd_t erase;
    ttcc_pkg::cell_cmd_t fin;
    ttcc_pkg::cell_cmd_t mid [2];
    logic [1:0] mid_n;
    logic [7:0] ch;
    logic       row_wrap;

    ch = chr.char_in;
    cursor_col_next     = cursor_col;
    cursor_row_next     = cursor_row;
    colour_index_next   = colour_index;
    colour_pending_next = colour_pending;
    mid_n = 2'd0;
    mid[0] = '{command: ttcc_pkg::CMD_SCROLL, glyph: 8'd0, cell_col: 7'd0,
               cell_row: 6'd0, rgb: 24'd0};
    mid[1] = mid[0];
    row_wrap = (({1'b0, cursor_row} + 7'd1) >= eff_rows);

    erase = '{command: ttcc_pkg::CMD_DRAW, glyph: ttcc_pkg::CH_CURSOR,
              cell_col: cursor_col, cell_row: cursor_row, rgb: 24'd0};

    priority if (colour_pending) begin
      colour_pending_next = 1'b0;
      colour_index_next   = ch;
    end else if (ch == ttcc_pkg::CH_BACKSPACE) begin
      if (cursor_col != 7'd0) begin
        cursor_col_next = cursor_col - 7'd1;
      end else if (cursor_row != 6'd0) begin
        cursor_row_next = cursor_row - 6'd1;
        cursor_col_next = 7'(eff_cols - 8'd1);
      end
      mid[0] = '{command: ttcc_pkg::CMD_CLEAR_CELL, glyph: 8'd0,
                 cell_col: cursor_col_next, cell_row: cursor_row_next, rgb: 24'd0};
      mid_n = 2'd1;
    end else if (ch == ttcc_pkg::CH_NEWLINE) begin
      cursor_col_next = 7'd0;
      if (row_wrap) begin
        mid_n = 2'd1;
      end else begin
        cursor_row_next = cursor_row + 6'd1;
      end
    end else if (ch == clear_code) begin
      mid[0] = '{command: ttcc_pkg::CMD_CLEAR_SCREEN, glyph: 8'd0, cell_col: 7'd0,
                 cell_row: 6'd0, rgb: 24'd0};
      mid_n = 2'd1;
      cursor_col_next = 7'd0;
      cursor_row_next = 6'd0;
    end else if (ch == ttcc_pkg::CH_ESC_COLOUR) begin
      colour_pending_next = 1'b1;
    end else begin
      mid[0] = '{command: ttcc_pkg::CMD_DRAW, glyph: ch, cell_col: cursor_col,
                 cell_row: cursor_row, rgb: ttcc_pkg::pal_rgb(colour_index)};
      mid_n = 2'd1;
      if (({1'b0, cursor_col} + 8'd1) >= eff_cols) begin
        cursor_col_next = 7'd0;
        if (row_wrap) begin
          mid_n = 2'd2;
        end else begin
          cursor_row_next = cursor_row + 6'd1;
        end
      end else begin
        cursor_col_next = cursor_col + 7'd1;
      end
    end

    fin = '{command: ttcc_pkg::CMD_DRAW, glyph: ttcc_pkg::CH_CURSOR,
            cell_col: cursor_col_next, cell_row: cursor_row_next,
            rgb: ttcc_pkg::pal_rgb(colour_index_next)};

    cbuf_next[0] = erase;
    cbuf_next[1] = (mid_n != 2'd0) ? mid[0] : fin;
    cbuf_next[2] = (mid_n == 2'd2) ? mid[1] : fin;
    cbuf_next[3] = fin;
    buf_cnt_m1_next = mid_n + 2'd1;
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      columns    <= ttcc_pkg::COLUMNS_RESET;
      rows       <= ttcc_pkg::ROWS_RESET;
      clear_code <= ttcc_pkg::CLEAR_CODE_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        ttcc_pkg::CFG_COLUMNS:    columns    <= cfg_data;
        ttcc_pkg::CFG_ROWS:       rows       <= cfg_data[6:0];
        ttcc_pkg::CFG_CLEAR_CODE: clear_code <= cfg_data;
        default: ;
      endcase
    end
  end

  // Terminal state advances once per accepted byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_col     <= 7'd0;
      cursor_row     <= 6'd0;
      colour_index   <= ttcc_pkg::COLOUR_RESET;
      colour_pending <= 1'b0;
    end else if (accept) begin
      cursor_col     <= cursor_col_next;
      cursor_row     <= cursor_row_next;
      colour_index   <= colour_index_next;
      colour_pending <= colour_pending_next;
    end
  end

  // Command buffer control.
  always_ff @(posedge clk) begin
    if (rst) begin
      buf_has    <= 1'b0;
      buf_idx    <= 2'd0;
      buf_cnt_m1 <= 2'd1;
    end else if (accept) begin
      buf_has    <= 1'b1;
      buf_idx    <= 2'd0;
      buf_cnt_m1 <= buf_cnt_m1_next;
    end else if (buf_done) begin
      buf_has <= 1'b0;
    end else if (buf_take) begin
      buf_idx <= buf_idx + 2'd1;
    end
  end

  // Command buffer payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      cbuf <= cbuf_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= buf_has;
    end
  end

  always_ff @(posedge clk) begin
    if (buf_take) begin
      out_cmd  <= cbuf[buf_idx];
      out_last <= (buf_idx == buf_cnt_m1);
    end
  end

  assign cmd.valid    = out_valid;
  assign cmd.command  = out_cmd.command;
  assign cmd.glyph    = out_cmd.glyph;
  assign cmd.cell_col = out_cmd.cell_col;
  assign cmd.cell_row = out_cmd.cell_row;
  assign cmd.rgb      = out_cmd.rgb;
  assign cmd.last     = out_last;

  // A byte always yields at least two commands.
  a_cnt_min: assert property (@(posedge clk) disable iff (rst)
    buf_has |-> (buf_cnt_m1 != 2'd0))
    else $error("command buffer holds fewer than two commands");

  // The buffer never reads past the byte's command count.
  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    buf_has |-> (buf_idx <= buf_cnt_m1))
    else $error("command buffer index past its count");

  // An accepted byte starts at the cursor erase in a filled buffer.
  a_accept_load: assert property (@(posedge clk) disable iff (rst)
    accept |=> (buf_has && (buf_idx == 2'd0) &&
                (cbuf[0].glyph == ttcc_pkg::CH_CURSOR)))
    else $error("accepted byte did not load the command buffer");

  // The final command of each byte redraws the cursor.
  a_last_cursor: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_last) |->
      ((out_cmd.command == ttcc_pkg::CMD_DRAW) &&
       (out_cmd.glyph == ttcc_pkg::CH_CURSOR)))
    else $error("final command is not a cursor redraw");

endmodule

`default_nettype wire
